@@ design/rmss_pkg.sv @@
// Package for the relay motor start sequencer.
// Holds the sequencer state type, register indexes and reset values.
// No dependencies.
package rmss_pkg;

   typedef enum logic [1:0] {
      SEQ_OFF   = 2'd0,
      SEQ_READY = 2'd1,
      SEQ_START = 2'd2,
      SEQ_ON    = 2'd3
   } seq_state_type;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned TIME_W      = 32;
   localparam int unsigned REQ_DATA_W  = 40;
   localparam int unsigned RSP_DATA_W  = 8;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type REG_DEBOUNCE  = 2'd0;
   localparam csr_index_type REG_MIN_OFF   = 2'd1;
   localparam csr_index_type REG_MIN_READY = 2'd2;
   localparam csr_index_type REG_MIN_START = 2'd3;

   localparam logic [CSR_DATA_W-1:0] DEBOUNCE_RST  = 16'd100;
   localparam logic [CSR_DATA_W-1:0] MIN_OFF_RST   = 16'd2000;
   localparam logic [CSR_DATA_W-1:0] MIN_READY_RST = 16'd500;
   localparam logic [CSR_DATA_W-1:0] MIN_START_RST = 16'd1000;

endpackage

@@ design/relay_motor_start_sequencer.sv @@
// Relay motor start sequencer: debounces the on/off request and steps two
// relays through off, ready, start and on with minimum dwell times.
// Depends on rmss_pkg.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_tvalid/req_tready  | req_tdata: now_ms, want_on
//  rsp     | out       | rsp_tvalid/rsp_tready  | rsp_tdata: state, relays, control
//  csr     | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// One transaction per clock sustained while rsp_tready is high; a request passes
// through the input register, then the update logic into the result register.
// The input register refills in the cycle it drains, so a stalled result
// only stops intake once both registers are full.
// Synchronous active-high reset restores the register defaults and the off
// state; csr writes are always taken.
module relay_motor_start_sequencer
   import rmss_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_W-1:0]     req_tdata,  // [31:0] now_ms, [32] want_on, zero fill
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_W-1:0]     rsp_tdata,  // [1:0] blade_state, [2] relay_a_on,
                                                 // [3] relay_b_on, [4] accepted_control
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  csr_index_type             csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   logic [CSR_DATA_W-1:0] debounce_ff, min_off_ff, min_ready_ff, min_start_ff;

   logic                  in_valid_ff;
   logic [TIME_W-1:0]     now_ff;
   logic                  want_ff;

   logic                  ctl_ff, ctl_in;
   seq_state_type         state_ff, state_in;
   logic [TIME_W-1:0]     agree_ff, agree_in;
   logic [TIME_W-1:0]     off_time_ff, off_time_in;
   logic [TIME_W-1:0]     ready_time_ff, ready_time_in;
   logic [TIME_W-1:0]     start_time_ff, start_time_in;

   logic                  out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;

   logic                  advance;
   logic                  relay_a, relay_b;
   logic [TIME_W-1:0]     since_agree, since_off, since_ready, since_start;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= DEBOUNCE_RST;
         min_off_ff   <= MIN_OFF_RST;
         min_ready_ff <= MIN_READY_RST;
         min_start_ff <= MIN_START_RST;
      end else if (csr_valid) begin
         case (csr_index)
            REG_DEBOUNCE:  debounce_ff  <= csr_data;
            REG_MIN_OFF:   min_off_ff   <= csr_data;
            REG_MIN_READY: min_ready_ff <= csr_data;
            REG_MIN_START: min_start_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         now_ff  <= req_tdata[TIME_W-1:0];
         want_ff <= req_tdata[TIME_W];
      end
   end

   assign since_agree = now_ff - agree_ff;
   assign since_off   = now_ff - off_time_ff;
   assign since_ready = now_ff - ready_time_ff;
   assign since_start = now_ff - start_time_ff;

   always_comb begin
      ctl_in        = ctl_ff;
      agree_in      = agree_ff;
      state_in      = state_ff;
      off_time_in   = off_time_ff;
      ready_time_in = ready_time_ff;
      start_time_in = start_time_ff;

      if (want_ff != ctl_ff) begin
         if (since_agree > {16'd0, debounce_ff}) begin
            ctl_in = want_ff;
         end
      end else begin
         agree_in = now_ff;
      end

      if (!ctl_in) begin
         state_in = SEQ_OFF;
         if (state_ff != SEQ_OFF) begin
            off_time_in = now_ff;
         end
      end else begin
         case (state_ff)
            SEQ_OFF: begin
               if (since_off > {16'd0, min_off_ff}) begin
                  state_in      = SEQ_READY;
                  ready_time_in = now_ff;
               end
            end
            SEQ_READY: begin
               if (since_ready > {16'd0, min_ready_ff}) begin
                  state_in      = SEQ_START;
                  start_time_in = now_ff;
               end
            end
            SEQ_START: begin
               if (since_start > {16'd0, min_start_ff}) begin
                  state_in = SEQ_ON;
               end
            end
            default: state_in = state_ff;
         endcase
      end

      case (state_in)
         SEQ_READY: begin relay_a = 1'b1; relay_b = 1'b0; end
         SEQ_START: begin relay_a = 1'b1; relay_b = 1'b1; end
         SEQ_ON:    begin relay_a = 1'b0; relay_b = 1'b1; end
         default:   begin relay_a = 1'b0; relay_b = 1'b0; end
      endcase

      out_data_in = {3'd0, ctl_in, relay_b, relay_a, state_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff        <= 1'b0;
         state_ff      <= SEQ_OFF;
         agree_ff      <= '0;
         off_time_ff   <= '0;
         ready_time_ff <= '0;
         start_time_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (advance) begin
            ctl_ff        <= ctl_in;
            state_ff      <= state_in;
            agree_ff      <= agree_in;
            off_time_ff   <= off_time_in;
            ready_time_ff <= ready_time_in;
            start_time_ff <= start_time_in;
            out_valid_ff  <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff  <= 1'b0;
         end
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   a_on_needs_control: assert property (@(posedge clock) disable iff (reset)
      (state_ff != SEQ_OFF) |-> ctl_ff)
      else $error("sequencer active while control is off");

   a_step_order: assert property (@(posedge clock) disable iff (reset)
      (advance && state_in != state_ff) |->
         (state_in == SEQ_OFF || state_in == seq_state_type'(state_ff + 2'd1)))
      else $error("sequencer skipped a state");

   a_relay_match: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff[2] == (out_data_ff[1:0] == SEQ_READY ||
                                           out_data_ff[1:0] == SEQ_START)) &&
                       (out_data_ff[3] == (out_data_ff[1:0] == SEQ_START ||
                                           out_data_ff[1:0] == SEQ_ON)))
      else $error("relay drive does not match state");

   a_result_from_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_data_ff[1:0] == state_ff && out_data_ff[4] == ctl_ff))
      else $error("result does not match updated state");

endmodule

@@ tb/relay_motor_start_sequencer_tb.sv @@
// Self-checking testbench for relay_motor_start_sequencer: stream stimulus,
// random flow control and a scoreboard that predicts every result.
// Depends on rmss_pkg and the relay_motor_start_sequencer RTL.
module relay_motor_start_sequencer_tb
   import rmss_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned NUM_PHASES      = 7;
   localparam int unsigned ITEMS_PER_PHASE = 150;
   localparam int unsigned LONG_HOLD       = 120;
   localparam int unsigned DRAIN_CYCLES    = 8;
   localparam int unsigned IDLE_LIMIT      = 2000;
   localparam int unsigned NUM_DIRECTED    = 20;

   localparam logic [TIME_W-1:0] DIR_STAMP [NUM_DIRECTED] = '{
      32'd0, 32'd50, 32'd100, 32'd101, 32'd2000, 32'd2001, 32'd2501, 32'd2502,
      32'd3502, 32'd3503, 32'd3550, 32'd3560, 32'd3661, 32'hFFFF_FFF0,
      32'h0000_0200, 32'h0000_0201, 32'h0000_0300, 32'hFFFF_FFFF, 32'd0,
      32'h7FFF_FFFF
   };
   localparam bit DIR_WANT [NUM_DIRECTED] = '{
      1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
      1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0
   };

   typedef struct packed {
      seq_state_type state;
      logic          relay_a;
      logic          relay_b;
      logic          control;
   } relay_output_type;

   class relay_sequence_scoreboard;
      logic [CSR_DATA_W-1:0] debounce, min_off, min_ready, min_start;
      logic                  ctrl_now;
      seq_state_type         seq, target;
      logic [TIME_W-1:0]     agree_mark, off_mark, ready_mark, start_mark;
      relay_output_type      pending_relay_outputs[$];
      int unsigned           errors, results_checked, on_seen;

      function new();
         debounce   = DEBOUNCE_RST;
         min_off    = MIN_OFF_RST;
         min_ready  = MIN_READY_RST;
         min_start  = MIN_START_RST;
         ctrl_now   = 1'b0;
         seq        = SEQ_OFF;
         target     = SEQ_OFF;
         agree_mark = '0;
         off_mark   = '0;
         ready_mark = '0;
         start_mark = '0;
         errors          = 0;
         results_checked = 0;
         on_seen         = 0;
      endfunction

      function automatic logic [TIME_W-1:0] since(logic [TIME_W-1:0] now,
                                                   logic [TIME_W-1:0] mark);
         return now - mark;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_DEBOUNCE:  debounce  = value;
            REG_MIN_OFF:   min_off   = value;
            REG_MIN_READY: min_ready = value;
            REG_MIN_START: min_start = value;
            default: ;
         endcase
      endfunction

      function void note_request(logic [TIME_W-1:0] now, logic want);
         seq_state_type    prior;
         relay_output_type res;
         if (want != ctrl_now) begin
            if (since(now, agree_mark) > {16'b0, debounce})
               ctrl_now = want;
         end else begin
            agree_mark = now;
         end
         prior = seq;
         if (!ctrl_now) begin
            target = SEQ_OFF;
            seq    = SEQ_OFF;
            if (prior != SEQ_OFF)
               off_mark = now;
         end
         case (seq)
            SEQ_OFF: begin
               if (ctrl_now)
                  target = SEQ_READY;
               if (target == SEQ_READY && since(now, off_mark) > {16'b0, min_off}) begin
                  seq        = SEQ_READY;
                  ready_mark = now;
               end
            end
            SEQ_READY: begin
               if (ctrl_now)
                  target = SEQ_START;
               if (target == SEQ_START && since(now, ready_mark) > {16'b0, min_ready}) begin
                  seq        = SEQ_START;
                  start_mark = now;
               end
            end
            SEQ_START: begin
               if (ctrl_now)
                  target = SEQ_ON;
               if (target == SEQ_OFF || target == SEQ_READY) begin
                  seq      = SEQ_OFF;
                  off_mark = now;
               end else if (target == SEQ_ON &&
                            since(now, start_mark) > {16'b0, min_start}) begin
                  seq = SEQ_ON;
               end
            end
            default: begin
               if (target == SEQ_OFF || target == SEQ_READY) begin
                  seq      = SEQ_OFF;
                  off_mark = now;
               end
            end
         endcase
         res.state   = seq;
         res.relay_a = (seq == SEQ_READY || seq == SEQ_START);
         res.relay_b = (seq == SEQ_START || seq == SEQ_ON);
         res.control = ctrl_now;
         pending_relay_outputs.push_back(res);
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] data);
         relay_output_type exp_res;
         if (pending_relay_outputs.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("[%0t] result with nothing pending: %h", $realtime, data);
            return;
         end
         exp_res = pending_relay_outputs.pop_front();
         results_checked++;
         if (exp_res.state == SEQ_ON)
            on_seen++;
         if (data[1:0] != exp_res.state || data[2] != exp_res.relay_a ||
             data[3] != exp_res.relay_b || data[4] != exp_res.control) begin
            errors++;
            if (errors <= 10)
               $display({"[%0t] mismatch: state %0d/%0d relay_a %b/%b ",
                         "relay_b %b/%b ctrl %b/%b (exp/act)"},
                        $realtime, exp_res.state, data[1:0], exp_res.relay_a, data[2],
                        exp_res.relay_b, data[3], exp_res.control, data[4]);
         end
      endfunction

      function int unsigned pending();
         return pending_relay_outputs.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [31:0] now_ms, [32] want_on, zero fill
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [1:0] blade_state, [2] relay_a_on,
                                       // [3] relay_b_on, [4] accepted_control
   logic                  csr_valid;
   logic                  csr_ready;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   relay_sequence_scoreboard sb = new();
   int unsigned idle_cycles   = 0;
   int unsigned hold_requests = 0;
   int unsigned items_sent    = 0;

   relay_motor_start_sequencer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready)
            sb.note_request(req_tdata[31:0], req_tdata[32]);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata);
         if ((csr_valid && csr_ready) || (req_tvalid && req_tready) ||
             (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("relay_motor_start_sequencer_tb: FAIL");
      $finish;
   end

   // receiver: stall on a rotating mask, with one long hold on request
   initial begin
      logic [15:0] mask;
      int unsigned holds_taken;
      holds_taken = 0;
      rsp_tready  = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (holds_taken != hold_requests) begin
            holds_taken++;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
            for (int i = 0; i < 32; i++) begin
               rsp_tready <= mask[i % 16];
               @(negedge clock);
            end
         end
      end
   end

   task automatic send_request(input logic [TIME_W-1:0] stamp, input logic want);
      req_tdata  <= {7'b0, want, stamp};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      csr_index_type         reg_order [4];
      logic [CSR_DATA_W-1:0] cfg [4];
      logic [TIME_W-1:0]     stamp;
      logic                  want_level, want_bit;
      int unsigned           run_left, sent, burst, gap, roll, lim, step_max;

      reg_order = '{REG_DEBOUNCE, REG_MIN_OFF, REG_MIN_READY, REG_MIN_START};
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = REG_DEBOUNCE;
      csr_data   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // walk the full sequence at reset settings, then the wrap cases
      for (int i = 0; i < NUM_DIRECTED; i++)
         send_request(DIR_STAMP[i], DIR_WANT[i]);
      req_tvalid <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         lim = ($urandom_range(0, 2) == 0) ? 300 : (($urandom_range(0, 1) == 0) ? 60 : 15);
         for (int r = 0; r < 4; r++) begin
            case (p)
               0:       cfg[r] = 16'h0000;
               1:       cfg[r] = 16'hFFFF;
               default: cfg[r] = 16'($urandom_range(0, lim));
            endcase
            write_csr(reg_order[r], cfg[r]);
         end
         csr_valid <= 1'b0;
         step_max = 3;
         for (int r = 0; r < 4; r++)
            if (cfg[r] / 4 + 3 > step_max)
               step_max = cfg[r] / 4 + 3;
         if (p == 3)
            hold_requests++;

         stamp      = $urandom;
         want_level = 1'b0;
         run_left   = 0;
         sent       = 0;
         while (sent < ITEMS_PER_PHASE) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst && sent < ITEMS_PER_PHASE; b++) begin
               if (run_left == 0) begin
                  want_level = 1'($urandom_range(0, 1));
                  run_left   = want_level ? $urandom_range(5, 40) : $urandom_range(1, 15);
               end
               run_left--;
               want_bit = ($urandom_range(0, 9) == 0) ? ~want_level : want_level;
               roll = $urandom_range(0, 99);
               if (roll < 4)
                  stamp = $urandom;
               else if (roll < 14)
                  stamp = stamp + cfg[$urandom_range(0, 3)] + $urandom_range(0, 1);
               else
                  stamp = stamp + $urandom_range(0, step_max);
               send_request(stamp, want_bit);
               sent++;
            end
            gap = (p % 3 == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         req_tvalid <= 1'b0;
      end

      wait_idle();
      $display("covered %0d timestamp updates over %0d register settings, %0d results checked",
               items_sent, NUM_PHASES + 1, sb.results_checked);
      $display("sequencer on in %0d results, %0d long output hold(s), %0d errors",
               sb.on_seen, hold_requests, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("relay_motor_start_sequencer_tb: PASS");
      else
         $display("relay_motor_start_sequencer_tb: FAIL");
      $finish;
   end

endmodule
